### sv/afc_pkg.sv
// Shared types and constants for the box-versus-frustum corner cull.
// No dependencies; every other file imports this package.
package afc_pkg;

  localparam int unsigned NumPlanes  = 6;
  localparam int unsigned NumCorners = 8;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned PlaneW     = 64;
  localparam int unsigned ProdW      = 2 * CoordW;
  // three products of magnitude up to 2^30 plus d scaled by 2^14
  localparam int unsigned SumW       = ProdW + 2;
  localparam int unsigned DShift     = 14;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned IdxLsb     = 3;
  localparam int unsigned IdxW       = 3;

  // box and partial verdict handed from cell to cell
  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic [2:0]               hint;
    logic [NumCorners-1:0]    alive;
  } token_t;

endpackage

### sv/afc_cell.sv
// One plane cell of the cull chain: holds one plane, tests all eight corners.
// Depends on afc_pkg.
module afc_cell
  import afc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              plane_we_i,
  input  logic [PlaneW-1:0] plane_wdata_i,
  output logic [PlaneW-1:0] plane_o,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  token_t            in_tok_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output token_t            out_tok_o
);

  logic [PlaneW-1:0] plane_q;
  logic signed [CoordW-1:0] coef_a, coef_b, coef_c, coef_d;

  logic va_q, vb_q, rdy_a, rdy_b;
  token_t tok_a_q, tok_b_q, tok_b_d;
  logic signed [ProdW-1:0] px_q [2];
  logic signed [ProdW-1:0] py_q [2];
  logic signed [ProdW-1:0] pz_q [2];
  logic signed [ProdW-1:0] px_d [2];
  logic signed [ProdW-1:0] py_d [2];
  logic signed [ProdW-1:0] pz_d [2];
  logic signed [SumW-1:0]  sum [NumCorners];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (plane_we_i) begin
      plane_q <= plane_wdata_i;
    end
  end

  assign plane_o = plane_q;
  assign coef_a  = plane_q[15:0];
  assign coef_b  = plane_q[31:16];
  assign coef_c  = plane_q[47:32];
  assign coef_d  = plane_q[63:48];

  assign rdy_b      = ~vb_q | out_ready_i;
  assign rdy_a      = ~va_q | rdy_b;
  assign in_ready_o = rdy_a;

  // stage A: six products, two per axis
  assign px_d[0] = coef_a * in_tok_i.min_x;
  assign px_d[1] = coef_a * in_tok_i.max_x;
  assign py_d[0] = coef_b * in_tok_i.min_y;
  assign py_d[1] = coef_b * in_tok_i.max_y;
  assign pz_d[0] = coef_c * in_tok_i.min_z;
  assign pz_d[1] = coef_c * in_tok_i.max_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      tok_a_q <= in_tok_i;
      px_q    <= px_d;
      py_q    <= py_d;
      pz_q    <= pz_d;
    end
    if (rdy_b && va_q) begin
      tok_b_q <= tok_b_d;
    end
  end

  // stage B: corner sums and sign test
  for (genvar k = 0; k < NumCorners; k++) begin : g_corner
    localparam logic [2:0] KB = 3'(k);
    assign sum[k] = SumW'(px_q[KB[0]]) + SumW'(py_q[KB[1]]) + SumW'(pz_q[KB[2]])
                  + (SumW'(coef_d) <<< DShift);
  end

  always_comb begin
    tok_b_d = tok_a_q;
    for (int k = 0; k < NumCorners; k++) begin
      tok_b_d.alive[k] = tok_a_q.alive[k] & ~sum[k][SumW-1];
    end
  end

  assign out_valid_o = vb_q;
  assign out_tok_o   = tok_b_q;

endmodule

### sv/aabb_frustum_corner_cull.sv
// Top level of the box-versus-frustum corner cull: cell chain, output register,
// configuration port. Depends on afc_pkg and afc_cell.
//
// While the output is not stalled, one box enters and one verdict leaves per
// cycle, through six plane cells of two stages each (product register, then
// the eight corner sums) and the output register. Each cell owns one plane
// and clears the inside bit of every corner whose plane sum a*x+b*y+c*z+d*2^14
// is negative, computed exactly. After the last cell the hint corner is taken if
// still inside, else the lowest inside corner; with no corner left the box is
// not visible and the hint comes back unchanged. Planes reset to zero, so
// every box is visible until the planes are written. Planes sit at byte
// addresses 0, 8, 16, 24, 32, 40 (left, right, top, bottom, near, far), each
// packing a, b, c, d as signed 16-bit values from the low bits up; write them
// only while no box is in flight. Each stage of the chain holds while the one
// after it is full and stalled, so the input keeps taking boxes into empty
// stages while a result waits on the output.
module aabb_frustum_corner_cull
  import afc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [15:0] min_x, [31:16] min_y, [47:32] min_z, [63:48] max_x,
  // [79:64] max_y, [95:80] max_z, [98:96] hint_corner, [103:99] zero
  input  logic [103:0]      s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [0] visible, [3:1] found_corner, [7:4] zero
  output logic [7:0]        m_axis_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [PlaneW-1:0] pwdata,
  output logic [PlaneW-1:0] prdata,
  output logic              pready
);

  logic [IdxW-1:0]   reg_idx;
  logic              wr_xfer;
  logic [PlaneW-1:0] plane [NumPlanes];

  logic   vld [NumPlanes+1];
  logic   rdy [NumPlanes+1];
  token_t tok [NumPlanes+1];

  logic       out_valid_q, out_rdy;
  logic       vis_d, vis_q;
  logic [2:0] found_d, found_q;
  token_t     last_tok;

  // configuration port: single-cycle access, register index from the 8-byte slot
  assign pready  = 1'b1;
  assign reg_idx = paddr[IdxLsb +: IdxW];
  assign wr_xfer = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    for (int i = 0; i < NumPlanes; i++) begin
      if (reg_idx == IdxW'(i)) prdata = plane[i];
    end
  end

  // head of the chain: every corner starts out inside
  always_comb begin
    tok[0]        = '0;
    tok[0].min_x  = s_axis_tdata[15:0];
    tok[0].min_y  = s_axis_tdata[31:16];
    tok[0].min_z  = s_axis_tdata[47:32];
    tok[0].max_x  = s_axis_tdata[63:48];
    tok[0].max_y  = s_axis_tdata[79:64];
    tok[0].max_z  = s_axis_tdata[95:80];
    tok[0].hint   = s_axis_tdata[98:96];
    tok[0].alive  = '1;
  end

  assign vld[0]        = s_axis_tvalid;
  assign s_axis_tready = rdy[0];

  for (genvar i = 0; i < NumPlanes; i++) begin : g_cell
    afc_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .plane_we_i    (wr_xfer && (reg_idx == IdxW'(i))),
      .plane_wdata_i (pwdata),
      .plane_o       (plane[i]),
      .in_valid_i    (vld[i]),
      .in_ready_o    (rdy[i]),
      .in_tok_i      (tok[i]),
      .out_valid_o   (vld[i+1]),
      .out_ready_i   (rdy[i+1]),
      .out_tok_o     (tok[i+1])
    );
  end

  // pick the hint if it survived, else the lowest surviving corner
  assign last_tok = tok[NumPlanes];
  always_comb begin
    vis_d   = |last_tok.alive;
    found_d = last_tok.hint;
    if (!last_tok.alive[last_tok.hint]) begin
      for (int k = NumCorners - 1; k >= 0; k--) begin
        if (last_tok.alive[k]) found_d = 3'(k);
      end
    end
  end

  // output register: advance when empty or when the current transfer completes
  assign out_rdy         = ~out_valid_q | m_axis_tready;
  assign rdy[NumPlanes]  = out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= vld[NumPlanes];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && vld[NumPlanes]) begin
      vis_q   <= vis_d;
      found_q <= found_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, found_q, vis_q};

endmodule

### sv/afc_checker.sv
// Port-level checks for aabb_frustum_corner_cull, bound to the top level.
// Depends on afc_pkg.
module afc_checker
  import afc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [7:0]        m_axis_tdata,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [AddrW-1:0]  paddr,
  input logic [PlaneW-1:0] pwdata,
  input logic [PlaneW-1:0] prdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an empty output means the whole chain can move, so the input is ready
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output empty");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:4] == 4'b0000)
    else $error("result padding not zero");

  // a plane written and read back at once returns the written value
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[IdxLsb +: IdxW] < IdxW'(NumPlanes))
    |=> !psel || pwrite || (paddr != $past(paddr)) || (prdata == $past(pwdata)))
    else $error("plane readback mismatch");

endmodule

bind aabb_frustum_corner_cull afc_checker u_afc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

### tb/sv/aabb_frustum_corner_cull_test.sv
// Testbench for aabb_frustum_corner_cull: streams boxes in, loads the six planes
// over the APB port and checks each verdict against a local predictor.
// Depends on afc_pkg and the RTL of the block.
module aabb_frustum_corner_cull_test;
  import afc_pkg::*;

  // box in to verdict out: the plane cell stages plus the output register
  localparam int unsigned PipeLatency = 13;
  // 1.0 in the Q2.14 normal format
  localparam int UnitNormal = 16384;

  typedef enum int unsigned {
    PlaneLeft,
    PlaneRight,
    PlaneTop,
    PlaneBottom,
    PlaneNear,
    PlaneFar
  } plane_sel_e;

  typedef struct {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
    logic [2:0]               hint;
  } box_t;

  typedef struct {
    logic       visible;
    logic [2:0] corner;
  } verdict_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // [15:0] min_x, [31:16] min_y, [47:32] min_z, [63:48] max_x,
  // [79:64] max_y, [95:80] max_z, [98:96] hint_corner, [103:99] zero
  logic [103:0]      s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [0] visible, [3:1] found_corner, [7:4] zero
  logic [7:0]        m_axis_tdata;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [AddrW-1:0]  paddr         = '0;
  logic [PlaneW-1:0] pwdata        = '0;
  logic [PlaneW-1:0] prdata;
  logic              pready;

  // planes as the block holds them, and the set to be loaded next
  logic [PlaneW-1:0] plane_shadow [NumPlanes] = '{default: '0};
  logic [PlaneW-1:0] next_planes  [NumPlanes] = '{default: '0};

  verdict_t pending_verdicts [$];
  verdict_t want_verdict;
  int       mismatch_count = 0;
  bit       sender_idles   = 1'b1;
  bit       sink_stalls    = 1'b1;

  aabb_frustum_corner_cull u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: test all eight corners against the shadow planes, exactly.
  // ---------------------------------------------------------------------------
  function automatic verdict_t cull_box(box_t box);
    logic signed [CoordW-1:0] cx, cy, cz;
    logic signed [CoordW-1:0] a, b, c, d;
    longint                   acc;
    logic [NumCorners-1:0]    alive;
    verdict_t                 v;
    alive = '1;
    for (int k = 0; k < NumCorners; k++) begin
      cx = ((k & 1) != 0) ? box.max_x : box.min_x;
      cy = ((k & 2) != 0) ? box.max_y : box.min_y;
      cz = ((k & 4) != 0) ? box.max_z : box.min_z;
      for (int p = 0; p < NumPlanes; p++) begin
        a   = plane_shadow[p][15:0];
        b   = plane_shadow[p][31:16];
        c   = plane_shadow[p][47:32];
        d   = plane_shadow[p][63:48];
        // d moves from 3 to 17 fraction bits to line up with the products
        acc = longint'(a) * longint'(cx) + longint'(b) * longint'(cy)
            + longint'(c) * longint'(cz) + longint'(d) * longint'(1 << DShift);
        // a sum of exactly zero stays inside
        if (acc < 0) alive[k] = 1'b0;
      end
    end
    // hint first; otherwise the lowest inside corner; none leaves the hint
    v.visible = 1'b0;
    v.corner  = box.hint;
    if (alive[box.hint]) begin
      v.visible = 1'b1;
    end else begin
      for (int k = NumCorners - 1; k >= 0; k--) begin
        if (alive[k]) begin
          v.visible = 1'b1;
          v.corner  = 3'(k);
        end
      end
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Box builders
  // ---------------------------------------------------------------------------
  function automatic box_t make_box(int mnx, int mny, int mnz, int mxx, int mxy, int mxz,
                                    int hint);
    box_t box;
    box.min_x = 16'(mnx);
    box.min_y = 16'(mny);
    box.min_z = 16'(mnz);
    box.max_x = 16'(mxx);
    box.max_y = 16'(mxy);
    box.max_z = 16'(mxz);
    box.hint  = 3'(hint);
    return box;
  endfunction

  // any bit pattern in every field
  function automatic box_t wide_box();
    return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // box of modest size around the slab region; now and then min and max swap
  function automatic box_t near_box();
    int lo [3];
    int hi [3];
    int ctr, half;
    for (int i = 0; i < 3; i++) begin
      ctr   = int'($urandom_range(0, 5600)) - 2800;
      half  = $urandom_range(0, 700);
      lo[i] = ctr - half;
      hi[i] = ctr + half;
    end
    if ($urandom_range(0, 15) == 0) begin
      return make_box(hi[0], hi[1], hi[2], lo[0], lo[1], lo[2], $urandom_range(0, 7));
    end
    return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom_range(0, 7));
  endfunction

  // a in the low bits, then b, c, d
  function automatic logic [PlaneW-1:0] pack_plane(int a, int b, int c, int d);
    return {16'(d), 16'(c), 16'(b), 16'(a)};
  endfunction

  // bound on one axis, slightly tilted by the other two
  function automatic logic [PlaneW-1:0] slab_plane(int axis, bit upper, int bound);
    int coef [3];
    for (int i = 0; i < 3; i++) coef[i] = int'($urandom_range(0, 4096)) - 2048;
    coef[axis] = upper ? -UnitNormal : UnitNormal;
    return pack_plane(coef[0], coef[1], coef[2], upper ? bound : -bound);
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Offer one box, hold it until the transfer, then queue its verdict.
  task automatic send_box(box_t box);
    int gap;
    gap = sender_idles ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, box.hint, box.max_z, box.max_y, box.max_x,
                      box.min_z, box.min_y, box.min_x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_verdicts.push_back(cull_box(box));
  endtask

  // Drop valid and hold off until every queued verdict has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; psel stays up so writes can run back to back.
  task automatic write_plane(plane_sel_e sel, logic [PlaneW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(8 * int'(sel));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    plane_shadow[sel] = value;
  endtask

  // Write all six planes from next_planes, only once the chain is empty.
  task automatic load_planes();
    wait_drained();
    repeat (PipeLatency + 4) @(posedge clk_i);
    for (int p = 0; p < NumPlanes; p++) write_plane(plane_sel_e'(p), next_planes[p]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall per verdict, and the field-by-field check.
  // ---------------------------------------------------------------------------
  initial begin : verdict_sink
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = sink_stalls ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("verdict with none pending", int'(m_axis_tdata), 0);
      end else begin
        want_verdict = pending_verdicts.pop_front();
        if (m_axis_tdata[0] !== want_verdict.visible)
          report_mismatch("visible", int'(m_axis_tdata[0]), int'(want_verdict.visible));
        if (m_axis_tdata[3:1] !== want_verdict.corner)
          report_mismatch("found_corner", int'(m_axis_tdata[3:1]),
                          int'(want_verdict.corner));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Planes still at reset: every box visible and the hint comes back.
  task automatic test_reset_planes();
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767, 0));
    // minimum above maximum, taken as given
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768, 7));
    for (int h = 1; h < 7; h++) send_box(wide_box() );
  endtask

  // Axis-aligned cube from 0 to 100.0 on each axis.
  task automatic test_directed_planes();
    next_planes[PlaneLeft]   = pack_plane(UnitNormal, 0, 0, 0);
    next_planes[PlaneRight]  = pack_plane(-UnitNormal, 0, 0, 800);
    next_planes[PlaneTop]    = pack_plane(0, UnitNormal, 0, 0);
    next_planes[PlaneBottom] = pack_plane(0, -UnitNormal, 0, 800);
    next_planes[PlaneNear]   = pack_plane(0, 0, UnitNormal, 0);
    next_planes[PlaneFar]    = pack_plane(0, 0, -UnitNormal, 800);
    load_planes();
    // whole box inside: the hint wins
    send_box(make_box(100, 100, 100, 200, 200, 200, 5));
    // whole box beyond the far side: not visible, hint unchanged
    send_box(make_box(900, 900, 900, 1000, 1000, 1000, 3));
    // box swallowing the cube: no corner inside, so culled
    send_box(make_box(-100, -100, -100, 1000, 1000, 1000, 6));
    // only the all-max corner inside
    send_box(make_box(-50, -50, -50, 50, 50, 50, 3));
    // odd corners inside, hint outside: lowest inside corner reported
    send_box(make_box(-50, 10, 10, 50, 20, 20, 2));
    // every corner lies exactly on planes: zero sums count as inside
    send_box(make_box(0, 0, 0, 800, 800, 800, 4));
    // minimum above maximum, all corners still inside
    send_box(make_box(200, 200, 200, 100, 100, 100, 0));
    // one step outside the left plane
    send_box(make_box(-1, 10, 10, -1, 20, 20, 1));
    // one step outside the far plane
    send_box(make_box(10, 10, 801, 20, 20, 801, 7));
  endtask

  // Extreme coefficients against full-range boxes; products reach 2^30.
  task automatic test_extreme_planes();
    logic [PlaneW-1:0] corner_case [4];
    corner_case = '{64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                    64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_7FFF_8000_7FFF};
    for (int s = 0; s < 4; s++) begin
      for (int p = 0; p < NumPlanes; p++) begin
        next_planes[p] = ((p % 2) == 0) ? corner_case[s] : corner_case[(s + 1) % 4];
      end
      load_planes();
      for (int n = 0; n < 30; n++) send_box(wide_box());
    end
  endtask

  // Random slabs with tilted normals, boxes near them: a mix of hits and culls.
  task automatic test_random_frustum();
    int lo, hi;
    for (int phase = 0; phase < 8; phase++) begin
      for (int axis = 0; axis < 3; axis++) begin
        lo = -int'($urandom_range(0, 2000));
        hi = $urandom_range(0, 2000);
        next_planes[2 * axis]     = slab_plane(axis, 1'b0, lo);
        next_planes[2 * axis + 1] = slab_plane(axis, 1'b1, hi);
      end
      load_planes();
      for (int n = 0; n < 140; n++) begin
        // hold the sender mid-phase until the chain has emptied
        if (n == 70 && (phase % 2) == 0) wait_drained();
        send_box(($urandom_range(0, 9) == 0) ? wide_box() : near_box());
      end
    end
  endtask

  // Back-to-back transfers on both sides.
  task automatic test_no_idle();
    sender_idles = 1'b0;
    sink_stalls  = 1'b0;
    for (int n = 0; n < 150; n++) send_box(near_box());
    wait_drained();
    sender_idles = 1'b1;
    sink_stalls  = 1'b1;
  endtask

  // Arbitrary plane words; some planes cleared so that boxes still get through.
  task automatic test_random_planes();
    for (int phase = 0; phase < 4; phase++) begin
      for (int p = 0; p < NumPlanes; p++) begin
        next_planes[p] = ($urandom_range(0, 2) == 0) ? '0 : {$urandom, $urandom};
      end
      load_planes();
      for (int n = 0; n < 60; n++) send_box(wide_box());
    end
  endtask

  // Write zero back into every plane: all boxes visible again.
  task automatic test_cleared_planes();
    for (int p = 0; p < NumPlanes; p++) next_planes[p] = '0;
    load_planes();
    for (int n = 0; n < 20; n++) send_box(wide_box());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_planes();
    test_directed_planes();
    test_extreme_planes();
    test_random_frustum();
    test_no_idle();
    test_random_planes();
    test_cleared_planes();
    // drain, then allow the chain to run dry
    wait_drained();
    repeat (PipeLatency + 8) @(posedge clk_i);
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
